>>> hw/rtl/drr_pkg.sv
// Shared types, constants and byte-level helpers for the discovery request responder.
// Depends on nothing; every module of the block imports it.
package drr_pkg;

    localparam int CountW    = 17;
    localparam int WordW     = 16;
    localparam int IdxW      = 5;
    localparam int PendW     = 5;
    localparam int TunerW    = 5;
    localparam int CfgIndexW = 1;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [CountW-1:0] MinFrame = CountW'(8);
    localparam logic [CountW-1:0] HdrLen   = CountW'(8);
    localparam logic [CountW-1:0] TypeEnd  = CountW'(2);
    localparam logic [CountW-1:0] LenEnd   = CountW'(4);

    localparam logic [WordW-1:0] ReqType = 16'h0002;
    localparam logic [WordW-1:0] RpyType = 16'h0003;

    localparam logic [IdxW-1:0] CrcSpan  = IdxW'(19);
    localparam logic [IdxW-1:0] ReplyEnd = IdxW'(22);

    localparam logic [PendW-1:0] PendMax = {PendW{1'b1}};

    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    localparam logic [7:0] TagDevType  = 8'h01;
    localparam logic [7:0] TagDevId    = 8'h02;
    localparam logic [7:0] TagTuners   = 8'h10;
    localparam logic [31:0] DevTypeVal = 32'h00000001;

    localparam logic [TunerW-1:0] TunerMin = TunerW'(1);
    localparam logic [TunerW-1:0] TunerMax = TunerW'(16);

    localparam logic [CfgIndexW-1:0] CFG_DEVICE_ID   = 1'b0;
    localparam logic [CfgIndexW-1:0] CFG_TUNER_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } out_item_t;

    typedef struct packed {
        logic [31:0]       device_id;
        logic [TunerW-1:0] tuner_count;
    } cfg_regs_t;

    // One byte of reflected CRC-32, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Clamp the reported tuner count into 1..16.
    function automatic logic [7:0] tuner_byte(input logic [TunerW-1:0] tc);
        logic [TunerW-1:0] t;
        t = tc;
        if (t < TunerMin) begin
            t = TunerMin;
        end
        if (t > TunerMax) begin
            t = TunerMax;
        end
        return 8'(t);
    endfunction

    // Fixed and configured bytes 0..18 of the reply.
    function automatic logic [7:0] reply_byte(input logic [IdxW-1:0] idx,
                                              input cfg_regs_t       cfg);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = RpyType[15:8];
            5'd1:    b = RpyType[7:0];
            5'd2:    b = 8'h00;
            5'd3:    b = 8'h0F;
            5'd4:    b = TagDevType;
            5'd5:    b = 8'h04;
            5'd6:    b = DevTypeVal[31:24];
            5'd7:    b = DevTypeVal[23:16];
            5'd8:    b = DevTypeVal[15:8];
            5'd9:    b = DevTypeVal[7:0];
            5'd10:   b = TagDevId;
            5'd11:   b = 8'h04;
            5'd12:   b = cfg.device_id[31:24];
            5'd13:   b = cfg.device_id[23:16];
            5'd14:   b = cfg.device_id[15:8];
            5'd15:   b = cfg.device_id[7:0];
            5'd16:   b = TagTuners;
            5'd17:   b = 8'h01;
            5'd18:   b = tuner_byte(cfg.tuner_count);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/drr_parser.sv
// Request parser: byte count, type and length capture, frame-end checks.
// Depends on drr_pkg.
module drr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rx_accept,
    input  drr_pkg::in_item_t  rx_item,
    output logic               frame_ok
);
    import drr_pkg::*;

    logic [CountW-1:0] count_reg, count_next, count_inc;
    logic [WordW-1:0]  type_reg, type_next, type_upd;
    logic [WordW-1:0]  len_reg, len_next, len_upd;
    logic              ok;

    always_comb begin
        count_inc = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
        type_upd  = type_reg;
        len_upd   = len_reg;
        if (count_reg < TypeEnd) begin
            type_upd = {type_reg[7:0], rx_item.rx_byte};
        end else if (count_reg < LenEnd) begin
            len_upd = {len_reg[7:0], rx_item.rx_byte};
        end
        ok = (count_inc >= MinFrame) && (type_upd == ReqType) &&
             ((CountW'(len_upd) + HdrLen) <= count_inc);

        count_next = count_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        frame_ok   = 1'b0;
        if (rx_accept) begin
            if (rx_item.rx_last) begin
                // frame end: start over whether or not a reply goes out
                frame_ok   = ok;
                count_next = '0;
                type_next  = '0;
                len_next   = '0;
            end else begin
                count_next = count_inc;
                type_next  = type_upd;
                len_next   = len_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
        end else begin
            count_reg <= count_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
        end
    end

endmodule

>>> hw/rtl/drr_reply_gen.sv
// Reply generator: pending-reply count, byte sequencer, running CRC, output register.
// Depends on drr_pkg.
module drr_reply_gen (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frame_ok,
    input  drr_pkg::cfg_regs_t cfg,
    output logic               pend_full,
    output logic               tx_valid,
    input  logic               tx_ready,
    output drr_pkg::out_item_t tx_item
);
    import drr_pkg::*;

    logic [PendW-1:0] pend_reg, pend_next;
    logic [IdxW-1:0]  idx_reg, idx_next, crc_off;
    logic [31:0]      crc_reg, crc_next, crc_base, crc_fin;
    logic             valid_reg, valid_next;
    out_item_t        item_reg, item_next;
    logic             load, done;
    logic [7:0]       cur_byte;

    always_comb begin
        load    = (pend_reg != '0) && (!valid_reg || tx_ready);
        done    = load && (idx_reg == ReplyEnd);
        crc_fin = ~crc_reg;
        crc_off = idx_reg - CrcSpan;

        if (idx_reg < CrcSpan) begin
            cur_byte = reply_byte(idx_reg, cfg);
        end else begin
            unique case (crc_off[1:0])
                2'd0: cur_byte = crc_fin[7:0];
                2'd1: cur_byte = crc_fin[15:8];
                2'd2: cur_byte = crc_fin[23:16];
                2'd3: cur_byte = crc_fin[31:24];
            endcase
        end

        crc_base = (idx_reg == '0) ? CrcInit : crc_reg;
        crc_next = crc_reg;
        idx_next = idx_reg;
        if (load) begin
            if (idx_reg < CrcSpan) begin
                crc_next = crc32_byte(crc_base, cur_byte);
            end
            idx_next = done ? '0 : idx_reg + 1'b1;
        end

        pend_next = pend_reg + PendW'(frame_ok) - PendW'(done);

        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next        = 1'b1;
            item_next.tx_byte = cur_byte;
            item_next.tx_last = done;
        end else if (tx_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        item_reg <= item_next;
    end

    assign pend_full = (pend_reg == PendMax);
    assign tx_valid  = valid_reg;
    assign tx_item   = item_reg;

endmodule

>>> hw/rtl/discovery_request_responder.sv
// Top level of the discovery request responder: configuration registers, parser, reply generator.
// Depends on drr_pkg, drr_parser and drr_reply_gen.
//
// The block takes a received datagram one byte per transaction on the s_ channel,
// rx_last flagging the final byte, and accepts a byte in every cycle while s_ready is
// high. At each frame end it checks length (at least 8 bytes), type (0x0002) and that
// the declared payload length plus 8 fits in the received length; the request CRC is ignored.
// A frame that passes queues one 23-byte reply, sent on the m_ channel one byte per
// cycle while m_ready is high: header 00 03 00 0F, tag 01 (value 1), tag 02 (device
// id), tag 10 (tuner count, clamped to 1..16), then CRC-32 of those 19 bytes,
// little-endian, tx_last on the final CRC byte. An accepted final request byte raises
// the pending count; the sequencer then loads each reply byte into the output register,
// folding bytes 0..18 into its running CRC register.
// Up to 31 replies wait in a pending count; s_ready drops only while that count is
// full. Every queued reply uses the configuration current at send time, so write
// cfg_index/cfg_data only while no reply is pending. No clearing pass after reset.
module discovery_request_responder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request byte stream
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  drr_pkg::in_item_t                    s_payload,
    // reply byte stream
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output drr_pkg::out_item_t                   m_payload,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [drr_pkg::CfgIndexW-1:0]        cfg_index,
    input  logic [31:0]                          cfg_data
);
    import drr_pkg::*;

    cfg_regs_t cfg_reg, cfg_next;
    logic      rx_accept;
    logic      frame_ok;
    logic      pend_full;

    // Configuration writes are always accepted; cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEVICE_ID:   cfg_next.device_id   = cfg_data;
                CFG_TUNER_COUNT: cfg_next.tuner_count = cfg_data[TunerW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_id   <= 32'h10000000;
            cfg_reg.tuner_count <= TunerMin;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold off requests only when no room is left to remember another reply.
    assign s_ready   = !pend_full;
    assign rx_accept = s_valid && s_ready;

    drr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_accept(rx_accept),
        .rx_item  (s_payload),
        .frame_ok (frame_ok)
    );

    drr_reply_gen u_reply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frame_ok (frame_ok),
        .cfg      (cfg_reg),
        .pend_full(pend_full),
        .tx_valid (m_valid),
        .tx_ready (m_ready),
        .tx_item  (m_payload)
    );

endmodule

>>> hw/rtl/drr_checker.sv
// Port-level checks for the discovery request responder, bound to the top level.
// Depends on drr_pkg and discovery_request_responder.
module drr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input drr_pkg::out_item_t m_payload
);
    import drr_pkg::*;

    logic [IdxW-1:0] pos_reg, pos_next;
    logic            out_acc;

    assign out_acc  = m_valid && m_ready;
    assign pos_next = out_acc ? ((pos_reg == ReplyEnd) ? '0 : pos_reg + 1'b1) : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("reply byte changed while stalled");

    // tx_last marks exactly the 23rd byte of each reply
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (m_payload.tx_last == (pos_reg == ReplyEnd)))
        else $error("tx_last out of place");

    // the reply type byte 0x03 is the second byte of every reply
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && (pos_reg == IdxW'(1)) |-> (m_payload.tx_byte == RpyType[7:0]))
        else $error("reply type byte wrong");

    // the clamped tuner count value at position 18 lies in 1..16
    a_tuner: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && (pos_reg == IdxW'(18)) |->
            (m_payload.tx_byte != 8'h00) && (m_payload.tx_byte <= 8'h10))
        else $error("tuner count out of range");

endmodule

bind discovery_request_responder drr_checker u_drr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
